### rtl/rrt_pkg.sv
package rrt_pkg;

  localparam int MaxNodes  = 1024;
  localparam int IdxW      = $clog2(MaxNodes);
  localparam int CntW      = IdxW + 1;
  localparam int CoordW    = 32;
  localparam int DiffW     = CoordW + 1;
  localparam int MagW      = CoordW;
  localparam int SqW       = 2 * MagW;
  localparam int DistW     = SqW + 1;
  localparam int StepW     = 31;
  localparam int RootW     = 33;
  localparam int SqrtSteps = RootW;
  localparam int RadW      = 2 * RootW;
  localparam int RemW      = RootW + 3;
  localparam int ProdW     = StepW + MagW;
  localparam int QuoW      = StepW;
  localparam int DivSteps  = ProdW;
  localparam int DivCntW   = $clog2(DivSteps);

  localparam logic [StepW-1:0] StepReset = StepW'(32768);

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_SAME   = 2'd3;

  localparam logic KIND_ROOT   = 1'b0;
  localparam logic KIND_EXTEND = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } sqrt_cell_t;

endpackage

### rtl/rrt_chan_if.sv
interface rrt_req_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [rrt_pkg::CoordW-1:0]   target_x;
  logic signed [rrt_pkg::CoordW-1:0]   target_y;

  modport source (output valid, kind, target_x, target_y, input ready);
  modport sink (input valid, kind, target_x, target_y, output ready);
endinterface

interface rrt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [rrt_pkg::IdxW-1:0]            new_index;
  logic [rrt_pkg::IdxW-1:0]            parent_index;
  logic signed [rrt_pkg::CoordW-1:0]   new_x;
  logic signed [rrt_pkg::CoordW-1:0]   new_y;

  modport source (output valid, status, new_index, parent_index, new_x, new_y, input ready);
  modport sink (input valid, status, new_index, parent_index, new_x, new_y, output ready);
endinterface

interface rrt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rrt_pkg::StepW-1:0]    step_size;

  modport source (output valid, step_size, input ready);
  modport sink (input valid, step_size, output ready);
endinterface

### rtl/rrt_tree_extend_step_core.sv
// Channel  Role    Payload
// req      sink    kind, target_x, target_y
// rsp      source  status, new_index, parent_index, new_x, new_y
// cfg      sink    step_size (always ready)
//
// Root, empty and full items go from accept to S_DONE, which loads rsp once
// no earlier result waits. Extend scans the N stored nodes, one node per cycle
// through the distance pipe, then runs the root cell chain and two 63-step
// shift-subtract divides for offsets; a target at its nearest node skips both.
// Reset empties the tree and sets step_size to 0.5; node memory is not cleared.
// A result waiting on rsp holds back only the next result, not the next accept.
module rrt_tree_extend_step_core (
  input logic       clk,
  input logic       rst,
  rrt_req_if.sink   req,
  rrt_rsp_if.source rsp,
  rrt_cfg_if.sink   cfg
);
  import rrt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SQGO  = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIVGO = 3'd5;
  localparam logic [2:0] S_DIVW  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic signed [DiffW:0] SatMax = (DiffW+1)'(64'sd2147483647);
  localparam logic signed [DiffW:0] SatMin = (DiffW+1)'(-64'sd2147483648);

  logic [2:0]               state;
  logic [StepW-1:0]         step;
  logic [CntW-1:0]          count;
  logic signed [CoordW-1:0] tx;
  logic signed [CoordW-1:0] ty;

  logic [1:0]               res_status;
  logic [IdxW-1:0]          res_nidx;
  logic [IdxW-1:0]          res_pidx;
  logic signed [CoordW-1:0] res_x;
  logic signed [CoordW-1:0] res_y;

  logic                     rsp_valid;
  logic [1:0]               rsp_status;
  logic [IdxW-1:0]          rsp_nidx;
  logic [IdxW-1:0]          rsp_pidx;
  logic signed [CoordW-1:0] rsp_x;
  logic signed [CoordW-1:0] rsp_y;

  logic                     accept;
  logic                     root_wr;
  logic                     ext_wr;
  logic                     ram_we;
  logic [IdxW-1:0]          ram_waddr;
  logic [CoordW-1:0]        ram_wx;
  logic [CoordW-1:0]        ram_wy;
  logic [CoordW-1:0]        rdx;
  logic [CoordW-1:0]        rdy;

  logic [CntW-1:0]          iss;
  logic                     issuing;
  logic                     v1, v2, v3, v4;
  logic [IdxW-1:0]          idx1, idx2, idx3, idx4;
  logic signed [DiffW-1:0]  dx2, dy2, dx3, dy3, dx4, dy4;
  logic [MagW-1:0]          magx2, magy2;
  logic [SqW-1:0]           sqx3, sqy3;
  logic [DistW-1:0]         dist4;
  logic                     scan_done;

  logic                     best_ok;
  logic [DistW-1:0]         best_d;
  logic [IdxW-1:0]          best_idx;
  logic signed [DiffW-1:0]  best_dx;
  logic signed [DiffW-1:0]  best_dy;

  sqrt_cell_t               chain [SqrtSteps+1];
  logic                     sq_go;
  logic [RootW-1:0]         len;

  logic                     sel_y;
  logic signed [DiffW-1:0]  d_sel;
  logic signed [CoordW-1:0] t_sel;
  logic [MagW-1:0]          mag_sel;
  logic [ProdW-1:0]         prod;
  logic                     div_start;
  logic                     div_done;
  logic [QuoW-1:0]          quo;
  logic signed [DiffW-1:0]  base;
  logic signed [DiffW:0]    sum;
  logic signed [CoordW-1:0] sat_val;

  assign cfg.ready = 1'b1;
  assign req.ready = state == S_IDLE;
  assign accept    = req.valid && req.ready;

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.new_index    = rsp_nidx;
  assign rsp.parent_index = rsp_pidx;
  assign rsp.new_x        = rsp_x;
  assign rsp.new_y        = rsp_y;

  assign root_wr   = accept && (req.kind == KIND_ROOT);
  assign ext_wr    = (state == S_DIVW) && div_done && sel_y;
  assign ram_we    = root_wr || ext_wr;
  assign ram_waddr = root_wr ? '0 : count[IdxW-1:0];
  assign ram_wx    = root_wr ? req.target_x : res_x;
  assign ram_wy    = root_wr ? req.target_y : sat_val;

  rrt_ram #(.Width(CoordW), .Depth(MaxNodes)) u_ram_x (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wx),
    .raddr(iss[IdxW-1:0]), .rdata(rdx)
  );

  rrt_ram #(.Width(CoordW), .Depth(MaxNodes)) u_ram_y (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wy),
    .raddr(iss[IdxW-1:0]), .rdata(rdy)
  );

  assign issuing   = (state == S_SCAN) && (iss < count);
  assign scan_done = (state == S_SCAN) && (iss == count) && !v1 && !v2 && !v3 && !v4;
  assign magx2     = dx2[DiffW-1] ? MagW'(-dx2) : dx2[MagW-1:0];
  assign magy2     = dy2[DiffW-1] ? MagW'(-dy2) : dy2[MagW-1:0];

  always_ff @(posedge clk) begin
    idx1  <= iss[IdxW-1:0];
    idx2  <= idx1;
    dx2   <= {tx[CoordW-1], tx} - {rdx[CoordW-1], rdx};
    dy2   <= {ty[CoordW-1], ty} - {rdy[CoordW-1], rdy};
    idx3  <= idx2;
    dx3   <= dx2;
    dy3   <= dy2;
    sqx3  <= magx2 * magx2;
    sqy3  <= magy2 * magy2;
    idx4  <= idx3;
    dx4   <= dx3;
    dy4   <= dy3;
    dist4 <= {1'b0, sqx3} + {1'b0, sqy3};
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign sq_go    = state == S_SQGO;
  assign chain[0] = '{valid: sq_go, rem: '0, root: '0, rad: {1'b0, best_d}};

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_cell
    rrt_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .prev(chain[g]), .next(chain[g+1])
    );
  end

  assign d_sel     = sel_y ? best_dy : best_dx;
  assign t_sel     = sel_y ? ty : tx;
  assign mag_sel   = d_sel[DiffW-1] ? MagW'(-d_sel) : d_sel[MagW-1:0];
  assign div_start = state == S_DIVGO;
  assign base      = {t_sel[CoordW-1], t_sel} - d_sel;
  assign sum       = d_sel[DiffW-1] ? {base[DiffW-1], base} - (DiffW+1)'(quo)
                                    : {base[DiffW-1], base} + (DiffW+1)'(quo);

  always_comb begin
    if (sum > SatMax) begin
      sat_val = SatMax[CoordW-1:0];
    end else if (sum < SatMin) begin
      sat_val = SatMin[CoordW-1:0];
    end else begin
      sat_val = sum[CoordW-1:0];
    end
  end

  rrt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor(len), .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (v4 && (!best_ok || dist4 < best_d)) begin
      best_d   <= dist4;
      best_idx <= idx4;
      best_dx  <= dx4;
      best_dy  <= dy4;
    end
    if (chain[SqrtSteps].valid) begin
      len <= chain[SqrtSteps].root;
    end
    prod <= ProdW'(step) * ProdW'(mag_sel);
    if (rst) begin
      state     <= S_IDLE;
      step      <= StepReset;
      count     <= '0;
      rsp_valid <= 1'b0;
      iss       <= '0;
      best_ok   <= 1'b0;
      sel_y     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        step <= cfg.step_size;
      end
      if (v4) begin
        best_ok <= 1'b1;
      end
      if (issuing) begin
        iss <= iss + 1'b1;
      end
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tx       <= req.target_x;
            ty       <= req.target_y;
            res_nidx <= '0;
            res_pidx <= '0;
            if (req.kind == KIND_ROOT) begin
              count      <= CntW'(1);
              res_status <= ST_STORED;
              res_x      <= req.target_x;
              res_y      <= req.target_y;
              state      <= S_DONE;
            end else if (count == '0) begin
              res_status <= ST_EMPTY;
              res_x      <= '0;
              res_y      <= '0;
              state      <= S_DONE;
            end else if (count >= CntW'(MaxNodes)) begin
              res_status <= ST_FULL;
              res_x      <= '0;
              res_y      <= '0;
              state      <= S_DONE;
            end else begin
              res_status <= ST_STORED;
              res_x      <= '0;
              res_y      <= '0;
              iss        <= '0;
              best_ok    <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            res_pidx <= best_idx;
            if (best_d == '0) begin
              res_status <= ST_SAME;
              res_x      <= tx;
              res_y      <= ty;
              state      <= S_DONE;
            end else begin
              state <= S_SQGO;
            end
          end
        end
        S_SQGO: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (chain[SqrtSteps].valid) begin
            sel_y <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            if (!sel_y) begin
              res_x <= sat_val;
              sel_y <= 1'b1;
              state <= S_MUL;
            end else begin
              res_y      <= sat_val;
              res_nidx   <= count[IdxW-1:0];
              res_status <= ST_STORED;
              count      <= count + 1'b1;
              state      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_nidx   <= res_nidx;
            rsp_pidx   <= res_pidx;
            rsp_x      <= res_x;
            rsp_y      <= res_y;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxNodes))
    else $error("node count beyond capacity");

  a_root_latency: assert property (@(posedge clk) disable iff (rst)
    sq_go |-> ##SqrtSteps chain[SqrtSteps].valid)
    else $error("root chain lost an item");

  a_store_count: assert property (@(posedge clk) disable iff (rst)
    ext_wr |=> count == $past(count) + 1'b1)
    else $error("store without count advance");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!rsp_valid || rsp.ready)) |=> rsp_valid && state == S_IDLE)
    else $error("result not presented");

endmodule

### rtl/rrt_ram.sv
module rrt_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rrt_sqrt_cell.sv
module rrt_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  rrt_pkg::sqrt_cell_t prev,
  output rrt_pkg::sqrt_cell_t next
);
  import rrt_pkg::*;

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  logic            ge;

  assign rem_sh = {prev.rem[RemW-3:0], prev.rad[RadW-1 -: 2]};
  assign trial  = {1'b0, prev.root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    next.rem  <= ge ? rem_sh - trial : rem_sh;
    next.root <= {prev.root[RootW-2:0], ge};
    next.rad  <= {prev.rad[RadW-3:0], 2'b00};
    if (rst) begin
      next.valid <= 1'b0;
    end else begin
      next.valid <= prev.valid;
    end
  end

endmodule

### rtl/rrt_div.sv
module rrt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rrt_pkg::ProdW-1:0] dividend,
  input  logic [rrt_pkg::RootW-1:0] divisor,
  output logic                      done,
  output logic [rrt_pkg::QuoW-1:0]  quo
);
  import rrt_pkg::*;

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [ProdW-1:0]   num;
  logic [RootW:0]     rem;
  logic [RootW:0]     rem_sh;
  logic               ge;

  assign rem_sh = {rem[RootW-1:0], num[ProdW-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DivCntW'(DivSteps - 1);
        num  <= dividend;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        num <= {num[ProdW-2:0], 1'b0};
        rem <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
        quo <= {quo[QuoW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### dv/rrt_tree_extend_step_core_test.sv
`timescale 1ns / 100ps

module rrt_tree_extend_step_core_test;
  import rrt_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [IdxW-1:0]   new_index;
    logic [IdxW-1:0]   parent_index;
    logic [CoordW-1:0] new_x;
    logic [CoordW-1:0] new_y;
  } node_rsp_t;

  typedef struct {
    logic              kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    bit                typed;
    node_rsp_t         want;
  } seed_row_t;

  localparam logic [CoordW-1:0] CMIN = 32'h8000_0000;
  localparam logic [CoordW-1:0] CMAX = 32'h7fff_ffff;
  localparam int WatchLimit = 20000;

  logic clk;
  logic rst;

  rrt_req_if req_ch();
  rrt_rsp_if rsp_ch();
  rrt_cfg_if cfg_ch();

  rrt_tree_extend_step_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source),
    .cfg(cfg_ch.sink)
  );

  longint        tree_x [MaxNodes];
  longint        tree_y [MaxNodes];
  int            tree_parent [MaxNodes];
  int            tree_count;
  logic [StepW-1:0] step_len;

  node_rsp_t     pending_nodes [$];
  int            fail_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_left;
  bit            cur_typed;
  node_rsp_t     cur_want;
  int            quiet_cycles;

  seed_row_t seed_rows [] = '{
    '{KIND_EXTEND, 32'd0, 32'd0, 1'b1, '{ST_EMPTY, 10'd0, 10'd0, 32'd0, 32'd0}},
    '{KIND_ROOT, CMIN, CMAX, 1'b1, '{ST_STORED, 10'd0, 10'd0, CMIN, CMAX}},
    '{KIND_EXTEND, CMIN, CMAX, 1'b1, '{ST_SAME, 10'd0, 10'd0, CMIN, CMAX}},
    '{KIND_EXTEND, CMAX, CMIN, 1'b0, '0},
    '{KIND_EXTEND, CMAX, CMAX, 1'b0, '0},
    '{KIND_ROOT, 32'd0, 32'd0, 1'b1, '{ST_STORED, 10'd0, 10'd0, 32'd0, 32'd0}},
    '{KIND_EXTEND, 32'h0001_0000, 32'd0, 1'b1,
      '{ST_STORED, 10'd1, 10'd0, 32'h0000_8000, 32'd0}},
    '{KIND_EXTEND, 32'h0000_4000, 32'd0, 1'b0, '0},
    '{KIND_EXTEND, 32'd0, 32'd0, 1'b1, '{ST_SAME, 10'd0, 10'd0, 32'd0, 32'd0}},
    '{KIND_EXTEND, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
    '{KIND_EXTEND, CMIN, CMIN, 1'b0, '0},
    '{KIND_ROOT, 32'h7fff_0000, 32'h1234_5678, 1'b0, '0},
    '{KIND_EXTEND, 32'h7fff_0000, CMIN, 1'b0, '0},
    '{KIND_EXTEND, 32'h5555_aaaa, 32'haaaa_5555, 1'b0, '0}
  };

  function automatic logic [65:0] span_sq(longint ax, longint ay, longint bx, longint by);
    longint ddx;
    longint ddy;
    logic [65:0] mx;
    logic [65:0] my;
    ddx = bx - ax;
    ddy = by - ay;
    mx = (ddx < 0) ? 66'(-ddx) : 66'(ddx);
    my = (ddy < 0) ? 66'(-ddy) : 66'(ddy);
    return mx * mx + my * my;
  endfunction

  function automatic logic [32:0] floor_root(logic [65:0] d);
    logic [32:0] r;
    logic [32:0] c;
    logic [65:0] c2;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      c2 = 66'(c) * 66'(c);
      if (c2 <= d) r = c;
    end
    return r;
  endfunction

  function automatic longint steer_axis(longint base, longint d, logic [32:0] len);
    logic [63:0] m;
    logic [63:0] off;
    longint s;
    m = (d < 0) ? 64'(-d) : 64'(d);
    off = (64'(step_len) * m) / 64'(len);
    if (off > 64'h2_0000_0000) return (d < 0) ? -64'sd2147483648 : 64'sd2147483647;
    s = (d < 0) ? base - longint'(off) : base + longint'(off);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic node_rsp_t extend_tree(logic k, logic signed [31:0] tx,
                                            logic signed [31:0] ty);
    node_rsp_t r;
    int best;
    logic [65:0] bd;
    logic [65:0] d;
    logic [32:0] len;
    longint ox;
    longint oy;
    r = '0;
    if (k == KIND_ROOT) begin
      tree_x[0] = tx;
      tree_y[0] = ty;
      tree_parent[0] = 0;
      tree_count = 1;
      r.new_x = tx;
      r.new_y = ty;
    end else if (tree_count == 0) begin
      r.status = ST_EMPTY;
    end else if (tree_count >= MaxNodes) begin
      r.status = ST_FULL;
    end else begin
      best = 0;
      bd = span_sq(tree_x[0], tree_y[0], tx, ty);
      for (int i = 1; i < tree_count; i++) begin
        d = span_sq(tree_x[i], tree_y[i], tx, ty);
        if (d < bd) begin
          bd = d;
          best = i;
        end
      end
      r.parent_index = IdxW'(best);
      if (bd == 0) begin
        r.status = ST_SAME;
        r.new_x = tx;
        r.new_y = ty;
      end else begin
        len = floor_root(bd);
        ox = steer_axis(tree_x[best], longint'(tx) - tree_x[best], len);
        oy = steer_axis(tree_y[best], longint'(ty) - tree_y[best], len);
        r.status = ST_STORED;
        r.new_index = IdxW'(tree_count);
        r.new_x = ox[31:0];
        r.new_y = oy[31:0];
        tree_x[tree_count] = longint'($signed(ox[31:0]));
        tree_y[tree_count] = longint'($signed(oy[31:0]));
        tree_parent[tree_count] = best;
        tree_count++;
      end
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    node_rsp_t p;
    node_rsp_t got;
    if (!rst && req_ch.valid && req_ch.ready) begin
      p = extend_tree(req_ch.kind, req_ch.target_x, req_ch.target_y);
      pending_nodes = {pending_nodes, (cur_typed ? cur_want : p)};
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.status, rsp_ch.new_index, rsp_ch.parent_index,
              rsp_ch.new_x, rsp_ch.new_y};
      if (pending_nodes.size() == 0) begin
        $error("unexpected item status=%0d", got.status);
        fail_count++;
      end else begin
        p = pending_nodes.pop_front();
        if (got.status !== p.status) begin
          $error("status exp %0d got %0d", p.status, got.status);
          fail_count++;
        end
        if (got.new_index !== p.new_index) begin
          $error("new_index exp %0d got %0d", p.new_index, got.new_index);
          fail_count++;
        end
        if (got.parent_index !== p.parent_index) begin
          $error("parent_index exp %0d got %0d", p.parent_index, got.parent_index);
          fail_count++;
        end
        if (got.new_x !== p.new_x) begin
          $error("new_x exp %h got %h", p.new_x, got.new_x);
          fail_count++;
        end
        if (got.new_y !== p.new_y) begin
          $error("new_y exp %h got %h", p.new_y, got.new_y);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // hold ready low for a long stretch when asked, else stall at random
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_node(logic k, logic [31:0] x, logic [31:0] y, bit typed,
                           node_rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.kind = k;
    req_ch.target_x = x;
    req_ch.target_y = y;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_tree;
    req_ch.valid = 1'b0;
    while (pending_nodes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_step(logic [StepW-1:0] v);
    cfg_ch.valid = 1'b1;
    cfg_ch.step_size = v;
    do @(posedge clk); while (!cfg_ch.ready);
    step_len = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [31:0] near_coord(longint base);
    longint v;
    v = base + longint'($signed($urandom_range(0, 32'h0004_0000))) - 64'sd131072;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic random_nodes(int n);
    int pick;
    int idx;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      idx = (tree_count > 0) ? $urandom_range(tree_count - 1) : 0;
      if (pick < 4 || tree_count == 0) begin
        send_node(KIND_ROOT, $urandom, $urandom, 1'b0, '0);
      end else if (pick < 14) begin
        send_node(KIND_EXTEND, tree_x[idx][31:0], tree_y[idx][31:0], 1'b0, '0);
      end else if (pick < 55) begin
        send_node(KIND_EXTEND, $urandom, $urandom, 1'b0, '0);
      end else begin
        send_node(KIND_EXTEND, near_coord(tree_x[idx]), near_coord(tree_y[idx]),
                  1'b0, '0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_ROOT;
    req_ch.target_x = '0;
    req_ch.target_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.step_size = '0;
    tree_count = 0;
    step_len = StepReset;
    fail_count = 0;
    hold_left = 0;
    cur_typed = 1'b0;
    cur_want = '0;
    quiet_cycles = 0;
    send_idle_pct = 36;
    recv_idle_pct = 58;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (seed_rows[i])
      send_node(seed_rows[i].kind, seed_rows[i].x, seed_rows[i].y,
                seed_rows[i].typed, seed_rows[i].want);
    drain_tree();
    cur_typed = 1'b0;
    hold_left = 3000;
    random_nodes(125);
    drain_tree();

    send_idle_pct = 58;
    recv_idle_pct = 36;
    write_step(StepW'(1));
    random_nodes(125);
    drain_tree();
    write_step(StepW'(32'h7fff_ffff));
    random_nodes(125);
    drain_tree();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_step(StepW'($urandom_range(1, 32'h7fff_ffff)));
    random_nodes(125);
    drain_tree();

    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_nodes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
